FILE: sv/tdfu_pkg.sv
package tdfu_pkg;

    localparam int CW        = 24;
    localparam int VW        = CW - 1;
    localparam int DIV_STEPS = 25;
    localparam int SQ_STEPS  = 25;

    typedef struct packed {
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_z;
        logic [VW-1:0]        field_at_b;
    } t_in;

    typedef struct packed {
        logic          reached;
        logic [CW-1:0] field_at_c;
    } t_out;

endpackage

FILE: sv/triangle_distance_field_update_unit.sv
// Throughput: one transaction per cycle while the skid stage is empty; 25 restoring
// divider stages and 25 square-root stages each resolve one quotient or root bit.
// A two-entry output register and skid stage decouple the result from the pipeline.
// Reset (i_rst_n low, synchronous) clears all valid bits; the datapath is not reset.
module triangle_distance_field_update_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tdfu_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output tdfu_pkg::t_out o_data
);

    localparam int NSTG = 5 + tdfu_pkg::DIV_STEPS + 2 + tdfu_pkg::SQ_STEPS + 2;

    typedef struct packed {
        logic        rej;
        logic        dneg;
        logic [47:0] rn;
        logic [47:0] bq;
        logic [23:0] cn;
        logic [95:0] rb;
        logic [95:0] bc;
        logic [24:0] cb;
        logic [95:0] a2;
        logic [97:0] ba;
        logic [47:0] cq;
    } t_dv;

    typedef struct packed {
        logic [27:0] rem;
        logic [24:0] root;
        logic [49:0] x;
    } t_sq;

    typedef struct packed {
        logic rej;
        t_sq  s1;
        t_sq  s2;
        t_sq  sl;
    } t_qs;

    function automatic t_dv dv_step(t_dv s);
        t_dv         o;
        logic [48:0] tn;
        logic [48:0] dn;
        logic [96:0] tb;
        logic [96:0] db;
        o  = s;
        tn = {s.rn, 1'b0};
        dn = tn - {1'b0, s.bq};
        tb = {s.rb, 1'b0};
        db = tb - {1'b0, s.bc};
        if (tn >= {1'b0, s.bq}) begin
            o.rn = dn[47:0];
            o.cn = {s.cn[22:0], 1'b1};
        end else begin
            o.rn = tn[47:0];
            o.cn = {s.cn[22:0], 1'b0};
        end
        if (tb >= {1'b0, s.bc}) begin
            o.rb = db[95:0];
            o.cb = {s.cb[23:0], 1'b1};
        end else begin
            o.rb = tb[95:0];
            o.cb = {s.cb[23:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_sq sq_step(t_sq s);
        t_sq         o;
        logic [27:0] r;
        logic [27:0] t;
        r   = {s.rem[25:0], s.x[49:48]};
        t   = {1'b0, s.root, 2'b01};
        o.x = {s.x[47:0], 2'b00};
        if (r >= t) begin
            o.rem  = r - t;
            o.root = {s.root[23:0], 1'b1};
        end else begin
            o.rem  = r;
            o.root = {s.root[23:0], 1'b0};
        end
        return o;
    endfunction

    logic            en;
    logic            push;
    logic            take;
    logic [NSTG-1:0] r_vld;
    logic            r_out_valid;
    logic            r_skid_valid;
    tdfu_pkg::t_out  r_out;
    tdfu_pkg::t_out  r_skid;
    tdfu_pkg::t_out  n_res;

    assign en      = ~r_skid_valid;
    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign push    = en & r_vld[NSTG-1];
    assign take    = r_out_valid & i_ready;

    // stage 1: component products
    logic signed [47:0] r1_pbb [3];
    logic signed [47:0] r1_pcc [3];
    logic signed [47:0] r1_pbc [3];
    logic [45:0]        r1_vq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pbb[0] <= i_data.b_x * i_data.b_x;
            r1_pbb[1] <= i_data.b_y * i_data.b_y;
            r1_pbb[2] <= i_data.b_z * i_data.b_z;
            r1_pcc[0] <= i_data.c_x * i_data.c_x;
            r1_pcc[1] <= i_data.c_y * i_data.c_y;
            r1_pcc[2] <= i_data.c_z * i_data.c_z;
            r1_pbc[0] <= i_data.b_x * i_data.c_x;
            r1_pbc[1] <= i_data.b_y * i_data.c_y;
            r1_pbc[2] <= i_data.b_z * i_data.c_z;
            r1_vq     <= i_data.field_at_b * i_data.field_at_b;
        end
    end

    // stage 2: norms and dot product
    logic [47:0]        r2_bq;
    logic [47:0]        r2_cq;
    logic signed [48:0] r2_dbc;
    logic [45:0]        r2_vq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_bq  <= 48'(r1_pbb[0] + r1_pbb[1] + r1_pbb[2]);
            r2_cq  <= 48'(r1_pcc[0] + r1_pcc[1] + r1_pcc[2]);
            r2_dbc <= 49'(r1_pbc[0]) + 49'(r1_pbc[1]) + 49'(r1_pbc[2]);
            r2_vq  <= r1_vq;
        end
    end

    // stage 3: dot(b,c-b), |c-b|^2, early rejects
    logic [49:0] r3_dba;
    logic [49:0] r3_aq;
    logic [47:0] r3_dm;
    logic [47:0] r3_bq;
    logic [47:0] r3_cq;
    logic [45:0] r3_vq;
    logic        r3_rej;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dba <= 50'(r2_dbc) - {2'b00, r2_bq};
            r3_aq  <= {2'b00, r2_cq} + {2'b00, r2_bq} - {r2_dbc, 1'b0};
            r3_dm  <= r2_dbc[47:0];
            r3_bq  <= r2_bq;
            r3_cq  <= r2_cq;
            r3_vq  <= r2_vq;
            r3_rej <= r2_dbc[48] || (r2_dbc == '0) || (r2_bq <= {2'b00, r2_vq});
        end
    end

    // stage 4: partial products of the wide products
    logic [47:0] r4_dd_hh, r4_dd_hl, r4_dd_ll;
    logic [47:0] r4_bc_hh, r4_bc_hl, r4_bc_lh, r4_bc_ll;
    logic [47:0] r4_aa_hh, r4_aa_hl, r4_aa_ll;
    logic [49:0] r4_ba_hh, r4_ba_lh;
    logic [47:0] r4_ba_hl, r4_ba_ll;
    logic [47:0] r4_bq;
    logic [47:0] r4_cq;
    logic [45:0] r4_vq;
    logic        r4_rej;
    logic        r4_dneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dd_hh <= r3_dm[47:24] * r3_dm[47:24];
            r4_dd_hl <= r3_dm[47:24] * r3_dm[23:0];
            r4_dd_ll <= r3_dm[23:0] * r3_dm[23:0];
            r4_bc_hh <= r3_bq[47:24] * r3_cq[47:24];
            r4_bc_hl <= r3_bq[47:24] * r3_cq[23:0];
            r4_bc_lh <= r3_bq[23:0] * r3_cq[47:24];
            r4_bc_ll <= r3_bq[23:0] * r3_cq[23:0];
            r4_aa_hh <= r3_dba[47:24] * r3_dba[47:24];
            r4_aa_hl <= r3_dba[47:24] * r3_dba[23:0];
            r4_aa_ll <= r3_dba[23:0] * r3_dba[23:0];
            r4_ba_hh <= r3_bq[47:24] * r3_aq[49:24];
            r4_ba_hl <= r3_bq[47:24] * r3_aq[23:0];
            r4_ba_lh <= r3_bq[23:0] * r3_aq[49:24];
            r4_ba_ll <= r3_bq[23:0] * r3_aq[23:0];
            r4_bq    <= r3_bq;
            r4_cq    <= r3_cq;
            r4_vq    <= r3_vq;
            r4_rej   <= r3_rej;
            r4_dneg  <= r3_dba[49];
        end
    end

    // stage 5: assemble wide products
    logic [95:0] r5_d2;
    logic [95:0] r5_bc;
    logic [95:0] r5_a2;
    logic [97:0] r5_ba;
    logic [47:0] r5_bq;
    logic [47:0] r5_cq;
    logic [45:0] r5_vq;
    logic        r5_rej;
    logic        r5_dneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_d2   <= (96'(r4_dd_hh) << 48) + (96'(r4_dd_hl) << 25) + 96'(r4_dd_ll);
            r5_bc   <= (96'(r4_bc_hh) << 48) + (96'(r4_bc_hl) << 24)
                     + (96'(r4_bc_lh) << 24) + 96'(r4_bc_ll);
            r5_a2   <= (96'(r4_aa_hh) << 48) + (96'(r4_aa_hl) << 25) + 96'(r4_aa_ll);
            r5_ba   <= (98'(r4_ba_hh) << 48) + (98'(r4_ba_hl) << 24)
                     + (98'(r4_ba_lh) << 24) + 98'(r4_ba_ll);
            r5_bq   <= r4_bq;
            r5_cq   <= r4_cq;
            r5_vq   <= r4_vq;
            r5_rej  <= r4_rej;
            r5_dneg <= r4_dneg;
        end
    end

    // divider pipeline: cn and cb, one quotient bit per stage
    t_dv n_dv0;
    t_dv r_dv [tdfu_pkg::DIV_STEPS];

    always_comb begin
        n_dv0      = '0;
        n_dv0.rej  = r5_rej;
        n_dv0.dneg = r5_dneg;
        n_dv0.rn   = 48'(r5_vq);
        n_dv0.bq   = r5_bq;
        n_dv0.bc   = r5_bc;
        n_dv0.a2   = r5_a2;
        n_dv0.ba   = r5_ba;
        n_dv0.cq   = r5_cq;
        if (r5_d2 >= r5_bc) begin
            n_dv0.rb = r5_d2 - r5_bc;
            n_dv0.cb = 25'd1;
        end else begin
            n_dv0.rb = r5_d2;
            n_dv0.cb = 25'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= n_dv0;
            for (int j = 1; j < tdfu_pkg::DIV_STEPS; j++) begin
                r_dv[j] <= dv_step(r_dv[j-1]);
            end
        end
    end

    // E1: cosine reject, cn * bq * |a|^2 partials, root operands
    t_dv         dl;
    logic [99:0] bax;
    logic [24:0] f1;
    logic [24:0] f2;
    logic [48:0] r6_pp [4];
    logic [49:0] r6_x1;
    logic [49:0] r6_x2;
    logic [95:0] r6_a2;
    logic [47:0] r6_cq;
    logic        r6_rej;
    logic        r6_dneg;

    assign dl  = r_dv[tdfu_pkg::DIV_STEPS-1];
    assign bax = {2'b00, dl.ba};
    assign f1  = 25'h100_0000 - dl.cb;
    assign f2  = 25'h100_0000 - {1'b0, dl.cn};

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r6_pp[k] <= dl.cn * bax[25*k +: 25];
            end
            r6_x1   <= dl.cb * dl.cn;
            r6_x2   <= f1 * f2;
            r6_a2   <= dl.a2;
            r6_cq   <= dl.cq;
            r6_rej  <= dl.rej || (dl.cb <= {1'b0, dl.cn});
            r6_dneg <= dl.dneg;
        end
    end

    // E2: right-hand side of the obtuse-angle test
    logic [123:0] r7_rhs;
    logic [95:0]  r7_a2;
    logic [49:0]  r7_x1;
    logic [49:0]  r7_x2;
    logic [47:0]  r7_cq;
    logic         r7_rej;
    logic         r7_dneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_rhs  <= 124'(r6_pp[0]) + (124'(r6_pp[1]) << 25)
                     + (124'(r6_pp[2]) << 50) + (124'(r6_pp[3]) << 75);
            r7_a2   <= r6_a2;
            r7_x1   <= r6_x1;
            r7_x2   <= r6_x2;
            r7_cq   <= r6_cq;
            r7_rej  <= r6_rej;
            r7_dneg <= r6_dneg;
        end
    end

    // square-root pipeline: three roots, one bit per stage
    t_qs n_qs0;
    t_qs r_qs [tdfu_pkg::SQ_STEPS];

    always_comb begin
        n_qs0.rej = r7_rej || (!r7_dneg && ({4'b0000, r7_a2, 24'b0} >= r7_rhs));
        n_qs0.s1  = sq_step('{rem: '0, root: '0, x: r7_x1});
        n_qs0.s2  = sq_step('{rem: '0, root: '0, x: r7_x2});
        n_qs0.sl  = sq_step('{rem: '0, root: '0, x: {2'b00, r7_cq}});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qs[0] <= n_qs0;
            for (int j = 1; j < tdfu_pkg::SQ_STEPS; j++) begin
                r_qs[j].rej <= r_qs[j-1].rej;
                r_qs[j].s1  <= sq_step(r_qs[j-1].s1);
                r_qs[j].s2  <= sq_step(r_qs[j-1].s2);
                r_qs[j].sl  <= sq_step(r_qs[j-1].sl);
            end
        end
    end

    // F1, F2: |c| * (s1 + s2)
    t_qs         ql;
    logic [25:0] r9_s;
    logic [23:0] r9_l;
    logic        r9_rej;
    logic [49:0] r10_p;
    logic        r10_rej;

    assign ql = r_qs[tdfu_pkg::SQ_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_s    <= 26'(ql.s1.root) + 26'(ql.s2.root);
            r9_l    <= ql.sl.root[23:0];
            r9_rej  <= ql.rej;
            r10_p   <= r9_l * r9_s;
            r10_rej <= r9_rej;
        end
    end

    always_comb begin
        n_res.reached = ~r10_rej;
        if (r10_rej) begin
            n_res.field_at_c = '0;
        end else if (|r10_p[49:48]) begin
            n_res.field_at_c = '1;
        end else begin
            n_res.field_at_c = r10_p[47:24];
        end
    end

    // valid chain and output/skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NSTG-2:0], i_valid};
            end
            if (r_skid_valid) begin
                if (take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (push) begin
                if (!r_out_valid || take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

endmodule

FILE: sv/tdfu_check.sv
module tdfu_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input tdfu_pkg::t_out o_data
);

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // a rejected transaction carries a zero field
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.reached |-> o_data.field_at_c == '0)
        else $error("rejected result with non-zero field");

    // input back-pressure only when the output register is occupied
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output");

    // skid drains before more transactions are taken
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready && i_ready |=> o_ready)
        else $error("skid stage did not drain");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("valid state not cleared by reset");

endmodule

bind triangle_distance_field_update_unit tdfu_check u_tdfu_check (.*);
